### sv/ir_remote_frame_transmitter_top_defines.svh
// ----------------------------------------------------------------------------
// IR remote frame transmitter: assertion macros
// Shorthand for concurrent checks clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef IR_REMOTE_FRAME_TRANSMITTER_TOP_DEFINES_SVH
`define IR_REMOTE_FRAME_TRANSMITTER_TOP_DEFINES_SVH

// condition holds at every edge
`define IRTX_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// same-cycle implication
`define IRTX_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IRTX_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/irtx_pkg.sv
// ----------------------------------------------------------------------------
// IR remote frame transmitter package
// Shared types, timing constants and register defaults.
// ----------------------------------------------------------------------------
package irtx_pkg;

  // default build parameters
  localparam int unsigned CARRIER_HALF_US = 13;
  localparam int unsigned BIT_MARK_US     = 434;
  localparam int unsigned FRAME_BITS      = 32;

  // fixed frame timing, microseconds
  localparam int unsigned LEADER_US       = 6750;
  localparam int unsigned LEADER_SPACE_US = 4520;
  localparam int unsigned GAP_US          = 44000;
  localparam int unsigned REPEAT_SPACE_US = 2220;
  localparam int unsigned TAIL_US         = 200000;

  localparam int unsigned CodeW   = 32;
  localparam int unsigned IdleW   = 20;
  localparam int unsigned TimeW   = 18;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned BtnW    = 8;

  // active-low button bytes
  localparam logic [BtnW-1:0] BTN_POWER    = 8'hFE;
  localparam logic [BtnW-1:0] BTN_VOL_UP   = 8'hEF;
  localparam logic [BtnW-1:0] BTN_INPUT    = 8'hFB;
  localparam logic [BtnW-1:0] BTN_VOL_DOWN = 8'h7D;
  localparam logic [BtnW-1:0] BTN_MUTE     = 8'hF7;

  // register defaults
  localparam logic [CodeW-1:0] RST_POWER_DOWN = 32'd1637877497;
  localparam logic [CodeW-1:0] RST_POWER_UP   = 32'd1637910137;
  localparam logic [CodeW-1:0] RST_VOL_UP     = 32'd1637888207;
  localparam logic [CodeW-1:0] RST_VOL_DOWN   = 32'd1637920847;
  localparam logic [CodeW-1:0] RST_INPUT      = 32'd1637878517;
  localparam logic [CodeW-1:0] RST_MUTE       = 32'd1637904527;
  localparam logic [IdleW-1:0] RST_IDLE_LIMIT = 20'd1000000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POWER_DOWN   = 3'd0,
    CFG_POWER_UP     = 3'd1,
    CFG_VOL_UP       = 3'd2,
    CFG_VOL_DOWN     = 3'd3,
    CFG_INPUT_SELECT = 3'd4,
    CFG_MUTE         = 3'd5,
    CFG_IDLE_LIMIT   = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE, PH_LEAD_MARK, PH_LEAD_SPACE, PH_BIT_MARK, PH_BIT_SPACE,
    PH_STOP_MARK, PH_GAP, PH_REP_MARK, PH_REP_SPACE, PH_REP_STOP,
    PH_TAIL, PH_EXTRA
  } phase_e;

  typedef struct packed {
    logic [CodeW-1:0] power_down_code;
    logic [CodeW-1:0] power_up_code;
    logic [CodeW-1:0] volume_up_code;
    logic [CodeW-1:0] volume_down_code;
    logic [CodeW-1:0] input_select_code;
    logic [CodeW-1:0] mute_code;
    logic [IdleW-1:0] idle_limit;
  } cfg_t;

  typedef struct packed {
    logic sleep_request;
    logic busy_res;
    logic ir_level;
  } res_t;

endpackage

### sv/ir_remote_frame_transmitter_top.sv
// An accepted beat passes the input holding register, then the output result register.
// Throughput: one beat per cycle unless the sink stalls; one microsecond tick per beat.
// Input holding register and output result register decouple the two stream sides.
// Reset (rst_ni low, async): engine idle, power flag off, idle count zero, codes at defaults.
// No clearing pass; the block takes beats from the first cycle after reset.
// ----------------------------------------------------------------------------
// IR remote frame transmitter top level
// Stream wrapper around the NEC-style frame engine and its register file.
// ----------------------------------------------------------------------------
module ir_remote_frame_transmitter_top #(
  parameter int unsigned CarrierHalfUs = irtx_pkg::CARRIER_HALF_US,
  parameter int unsigned BitMarkUs     = irtx_pkg::BIT_MARK_US,
  parameter int unsigned FrameBits     = irtx_pkg::FRAME_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // slave side: one beat per microsecond tick
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] buttons
  // master side
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,   // [0] ir_level, [1] busy_res,
                                                         // [2] sleep_request, [7:3] zero
  // register write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [irtx_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [irtx_pkg::CodeW-1:0]     cfg_data_i
);

  irtx_pkg::cfg_t            cfg;
  irtx_pkg::res_t            res, out_res_q;
  logic                      in_valid_q, out_valid_q, step;
  logic [irtx_pkg::BtnW-1:0] in_buttons_q;

  // a held beat moves to the output register when that register is free or draining
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_buttons_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= res;
    end
  end

  irtx_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  irtx_engine #(
    .CarrierHalfUs (CarrierHalfUs),
    .BitMarkUs     (BitMarkUs),
    .FrameBits     (FrameBits)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .buttons_i (in_buttons_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_res_q.sleep_request, out_res_q.busy_res,
                          out_res_q.ir_level};

endmodule

### sv/irtx_cfg_regs.sv
// ----------------------------------------------------------------------------
// IR remote frame transmitter: configuration registers
// Frame codes and idle limit, written one register per beat.
// ----------------------------------------------------------------------------
module irtx_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [irtx_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [irtx_pkg::CodeW-1:0]     cfg_data_i,
  output irtx_pkg::cfg_t                 cfg_o
);

  irtx_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        irtx_pkg::CFG_POWER_DOWN:   cfg_d.power_down_code   = cfg_data_i;
        irtx_pkg::CFG_POWER_UP:     cfg_d.power_up_code     = cfg_data_i;
        irtx_pkg::CFG_VOL_UP:       cfg_d.volume_up_code    = cfg_data_i;
        irtx_pkg::CFG_VOL_DOWN:     cfg_d.volume_down_code  = cfg_data_i;
        irtx_pkg::CFG_INPUT_SELECT: cfg_d.input_select_code = cfg_data_i;
        irtx_pkg::CFG_MUTE:         cfg_d.mute_code         = cfg_data_i;
        irtx_pkg::CFG_IDLE_LIMIT:   cfg_d.idle_limit        = cfg_data_i[irtx_pkg::IdleW-1:0];
        default: ; // unmapped index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_down_code   <= irtx_pkg::RST_POWER_DOWN;
      cfg_q.power_up_code     <= irtx_pkg::RST_POWER_UP;
      cfg_q.volume_up_code    <= irtx_pkg::RST_VOL_UP;
      cfg_q.volume_down_code  <= irtx_pkg::RST_VOL_DOWN;
      cfg_q.input_select_code <= irtx_pkg::RST_INPUT;
      cfg_q.mute_code         <= irtx_pkg::RST_MUTE;
      cfg_q.idle_limit        <= irtx_pkg::RST_IDLE_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/irtx_engine.sv
// ----------------------------------------------------------------------------
// IR remote frame transmitter: frame engine
// Phase sequencer, carrier counter and idle counter; one tick per step.
// ----------------------------------------------------------------------------
`include "ir_remote_frame_transmitter_top_defines.svh"

module irtx_engine #(
  parameter int unsigned CarrierHalfUs = irtx_pkg::CARRIER_HALF_US,
  parameter int unsigned BitMarkUs     = irtx_pkg::BIT_MARK_US,
  parameter int unsigned FrameBits     = irtx_pkg::FRAME_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [irtx_pkg::BtnW-1:0]   buttons_i,
  input  irtx_pkg::cfg_t              cfg_i,
  output irtx_pkg::res_t              res_o
);

  localparam int unsigned CarrierPeriod = 2 * CarrierHalfUs;
  localparam int unsigned CpcW          = (CarrierPeriod > 1) ? $clog2(CarrierPeriod) : 1;
  localparam int unsigned BlW           = $clog2(FrameBits + 1);
  localparam int unsigned TimeW         = irtx_pkg::TimeW;
  localparam int unsigned CodeW         = irtx_pkg::CodeW;
  localparam int unsigned IdleW         = irtx_pkg::IdleW;

  // mark lengths are whole carrier cycles
  localparam int unsigned LeadMarkTicks = (irtx_pkg::LEADER_US / CarrierPeriod) * CarrierPeriod;
  localparam int unsigned BitMarkTicks  = (BitMarkUs / CarrierPeriod) * CarrierPeriod;
  localparam int unsigned OneSpaceUs    = 3 * (BitMarkUs + 90);
  localparam int unsigned ZeroSpaceUs   = BitMarkUs + 81;

  typedef irtx_pkg::phase_e phase_e;

  function automatic logic is_mark(phase_e ph);
    return (ph == irtx_pkg::PH_LEAD_MARK) || (ph == irtx_pkg::PH_BIT_MARK) ||
           (ph == irtx_pkg::PH_STOP_MARK) || (ph == irtx_pkg::PH_REP_MARK) ||
           (ph == irtx_pkg::PH_REP_STOP);
  endfunction

  function automatic logic [TimeW-1:0] phase_len(phase_e ph, logic msb);
    logic [TimeW-1:0] len;
    len = '0;
    unique case (ph)
      irtx_pkg::PH_LEAD_MARK,
      irtx_pkg::PH_REP_MARK:   len = TimeW'(LeadMarkTicks);
      irtx_pkg::PH_LEAD_SPACE: len = TimeW'(irtx_pkg::LEADER_SPACE_US);
      irtx_pkg::PH_BIT_MARK,
      irtx_pkg::PH_STOP_MARK,
      irtx_pkg::PH_REP_STOP:   len = TimeW'(BitMarkTicks);
      irtx_pkg::PH_BIT_SPACE:  len = msb ? TimeW'(OneSpaceUs) : TimeW'(ZeroSpaceUs);
      irtx_pkg::PH_GAP:        len = TimeW'(irtx_pkg::GAP_US);
      irtx_pkg::PH_REP_SPACE:  len = TimeW'(irtx_pkg::REPEAT_SPACE_US);
      irtx_pkg::PH_TAIL,
      irtx_pkg::PH_EXTRA:      len = TimeW'(irtx_pkg::TAIL_US);
      default:                 len = '0;
    endcase
    return len;
  endfunction

  // a mark shorter than one carrier cycle falls through to its space
  function automatic phase_e skip_empty(phase_e ph);
    phase_e nx;
    nx = ph;
    if (is_mark(ph) && (phase_len(ph, 1'b0) == '0)) begin
      unique case (ph)
        irtx_pkg::PH_LEAD_MARK: nx = irtx_pkg::PH_LEAD_SPACE;
        irtx_pkg::PH_BIT_MARK:  nx = irtx_pkg::PH_BIT_SPACE;
        irtx_pkg::PH_STOP_MARK: nx = irtx_pkg::PH_GAP;
        irtx_pkg::PH_REP_MARK:  nx = irtx_pkg::PH_REP_SPACE;
        default:                nx = irtx_pkg::PH_TAIL;
      endcase
    end
    return nx;
  endfunction

  phase_e             phase_q, phase_d, ph_w, ph_nx;
  logic [TimeW-1:0]   time_left_q, time_left_d, tl_w, tl_dec;
  logic [CpcW-1:0]    cpc_q, cpc_d, cpc_w;
  logic [CpcW:0]      cpc_inc;
  logic [BlW-1:0]     bits_left_q, bits_left_d, bl_w, bl_a;
  logic [CodeW-1:0]   shift_q, shift_d, fs_w, fs_a, code;
  logic               power_on_q, power_on_d;
  logic               extra_q, extra_d, ext_w, ext_a;
  logic [IdleW-1:0]   idle_count_q, idle_count_d, idle_inc;
  logic               start, busy, level, sleep;

  // idle side: button decode, frame start, idle counting
  always_comb begin
    ph_w         = phase_q;
    tl_w         = time_left_q;
    cpc_w        = cpc_q;
    fs_w         = shift_q;
    bl_w         = bits_left_q;
    ext_w        = extra_q;
    power_on_d   = power_on_q;
    idle_count_d = idle_count_q;
    idle_inc     = idle_count_q + 1'b1;
    sleep        = 1'b0;
    start        = 1'b1;
    code         = '0;
    if (phase_q == irtx_pkg::PH_IDLE) begin
      unique case (buttons_i)
        irtx_pkg::BTN_POWER: begin
          code       = power_on_q ? cfg_i.power_down_code : cfg_i.power_up_code;
          power_on_d = !power_on_q;
        end
        irtx_pkg::BTN_VOL_UP:   code = cfg_i.volume_up_code;
        irtx_pkg::BTN_INPUT: begin
          code  = cfg_i.input_select_code;
          ext_w = 1'b1;
        end
        irtx_pkg::BTN_VOL_DOWN: code = cfg_i.volume_down_code;
        irtx_pkg::BTN_MUTE:     code = cfg_i.mute_code;
        default:                start = 1'b0;
      endcase
      if (start) begin
        idle_count_d = '0;
        fs_w         = code;
        bl_w         = BlW'(FrameBits);
        ph_w         = skip_empty(irtx_pkg::PH_LEAD_MARK);
        tl_w         = phase_len(ph_w, code[CodeW-1]);
        cpc_w        = '0;
      end else if (idle_inc >= cfg_i.idle_limit) begin
        sleep        = 1'b1;
        idle_count_d = '0;
      end else begin
        idle_count_d = idle_inc;
      end
    end
  end

  // busy side: carrier output, countdown, phase advance
  always_comb begin
    busy    = (ph_w != irtx_pkg::PH_IDLE);
    level   = busy && is_mark(ph_w) && (cpc_w < CpcW'(CarrierHalfUs));
    cpc_inc = {1'b0, cpc_w} + 1'b1;
    tl_dec  = tl_w - 1'b1;
    fs_a    = fs_w;
    bl_a    = bl_w;
    ext_a   = ext_w;
    ph_nx   = irtx_pkg::PH_IDLE;
    unique case (ph_w)
      irtx_pkg::PH_LEAD_MARK:  ph_nx = irtx_pkg::PH_LEAD_SPACE;
      irtx_pkg::PH_LEAD_SPACE: ph_nx = irtx_pkg::PH_BIT_MARK;
      irtx_pkg::PH_BIT_MARK:   ph_nx = irtx_pkg::PH_BIT_SPACE;
      irtx_pkg::PH_BIT_SPACE: begin
        fs_a  = {fs_w[CodeW-2:0], 1'b0};
        if (bl_w != '0) bl_a = bl_w - 1'b1;
        ph_nx = (bl_a != '0) ? irtx_pkg::PH_BIT_MARK : irtx_pkg::PH_STOP_MARK;
      end
      irtx_pkg::PH_STOP_MARK:  ph_nx = irtx_pkg::PH_GAP;
      irtx_pkg::PH_GAP:        ph_nx = irtx_pkg::PH_REP_MARK;
      irtx_pkg::PH_REP_MARK:   ph_nx = irtx_pkg::PH_REP_SPACE;
      irtx_pkg::PH_REP_SPACE:  ph_nx = irtx_pkg::PH_REP_STOP;
      irtx_pkg::PH_REP_STOP:   ph_nx = irtx_pkg::PH_TAIL;
      irtx_pkg::PH_TAIL:       ph_nx = ext_w ? irtx_pkg::PH_EXTRA : irtx_pkg::PH_IDLE;
      irtx_pkg::PH_EXTRA: begin
        ext_a = 1'b0;
        ph_nx = irtx_pkg::PH_IDLE;
      end
      default:                 ph_nx = irtx_pkg::PH_IDLE;
    endcase
    ph_nx = skip_empty(ph_nx);

    phase_d     = ph_w;
    time_left_d = tl_w;
    cpc_d       = cpc_w;
    shift_d     = fs_w;
    bits_left_d = bl_w;
    extra_d     = ext_w;
    if (busy) begin
      time_left_d = tl_dec;
      cpc_d = (cpc_inc >= (CpcW+1)'(CarrierPeriod)) ? '0 : cpc_inc[CpcW-1:0];
      if (tl_dec == '0) begin
        phase_d     = ph_nx;
        time_left_d = phase_len(ph_nx, fs_a[CodeW-1]);
        cpc_d       = '0;
        shift_d     = fs_a;
        bits_left_d = bl_a;
        extra_d     = ext_a;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= irtx_pkg::PH_IDLE;
      time_left_q  <= '0;
      cpc_q        <= '0;
      bits_left_q  <= '0;
      shift_q      <= '0;
      power_on_q   <= 1'b0;
      extra_q      <= 1'b0;
      idle_count_q <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      time_left_q  <= time_left_d;
      cpc_q        <= cpc_d;
      bits_left_q  <= bits_left_d;
      shift_q      <= shift_d;
      power_on_q   <= power_on_d;
      extra_q      <= extra_d;
      idle_count_q <= idle_count_d;
    end
  end

  assign res_o.ir_level      = level;
  assign res_o.busy_res      = busy;
  assign res_o.sleep_request = sleep;

  `IRTX_ASSERT_IMP(a_active_has_time, phase_q != irtx_pkg::PH_IDLE, time_left_q != '0, "active phase with no time left")
  `IRTX_ASSERT_NOW(a_cpc_range, (CpcW+1)'(cpc_q) < (CpcW+1)'(CarrierPeriod), "carrier count out of range")
  `IRTX_ASSERT_NXT(a_busy_keeps_power, step_i && phase_q != irtx_pkg::PH_IDLE, $stable(power_on_q), "power flag moved while busy")
  `IRTX_ASSERT_NXT(a_sleep_clears_idle, step_i && res_o.sleep_request, idle_count_q == '0, "idle count not cleared on sleep")

endmodule

### tb/tb_ir_remote_frame_transmitter_top.sv
// ----------------------------------------------------------------------------
// IR remote frame transmitter testbench
// Drives microsecond-tick beats of button bytes into the stream input and
// checks every output beat against a beat-exact model of the NEC frame engine.
// Covers idle counting and sleep pulses, button decode, the power frame start,
// buttons ignored while busy, and back-pressure.
// ----------------------------------------------------------------------------
module tb_ir_remote_frame_transmitter_top;

  // run guards
  localparam int unsigned CYCLE_LIMIT = 50_000;     // watchdog bound for the whole run
  localparam int unsigned HOLD_CYCLES = 400;        // long sink stall
  localparam int unsigned QUEUE_DEPTH = 8;          // pending button beats
  localparam int unsigned IDLE_PCT    = 28;         // idle cycles per hundred
  localparam int unsigned BUSY_BEATS  = 80;         // beats fed after the frame start

  // one pending input beat; calm beats run without idle cycles on either side
  typedef struct {
    logic [7:0] buttons;
    bit         calm;
  } btn_beat_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  // DUT ports, all driven from time zero
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [7:0]                   s_axis_tdata  = 8'hFF;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [7:0]                   m_axis_tdata;
  logic                         cfg_valid_i   = 1'b0;
  logic                         cfg_ready_o;
  logic [irtx_pkg::CfgIdxW-1:0] cfg_index_i   = '0;
  logic [irtx_pkg::CodeW-1:0]   cfg_data_i    = '0;

  ir_remote_frame_transmitter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Frame engine model: own copy of the registers and engine state
  // --------------------------------------------------------------------------
  irtx_pkg::cfg_t   reg_file;
  irtx_pkg::phase_e ph_q;
  int unsigned      left_q;      // ticks left in current phase
  int unsigned      carr_q;      // position inside the carrier period
  int unsigned      bits_q;      // data bits still to send
  logic [31:0]      shift_q;     // frame code, MSB goes out next
  bit               pwr_on_q;
  bit               extra_q;     // input select asks for a second tail
  logic [19:0]      idle_cnt_q;

  initial begin
    reg_file.power_down_code   = irtx_pkg::RST_POWER_DOWN;
    reg_file.power_up_code     = irtx_pkg::RST_POWER_UP;
    reg_file.volume_up_code    = irtx_pkg::RST_VOL_UP;
    reg_file.volume_down_code  = irtx_pkg::RST_VOL_DOWN;
    reg_file.input_select_code = irtx_pkg::RST_INPUT;
    reg_file.mute_code         = irtx_pkg::RST_MUTE;
    reg_file.idle_limit        = irtx_pkg::RST_IDLE_LIMIT;
    ph_q       = irtx_pkg::PH_IDLE;
    left_q     = 0;
    carr_q     = 0;
    bits_q     = 0;
    shift_q    = '0;
    pwr_on_q   = 1'b0;
    extra_q    = 1'b0;
    idle_cnt_q = '0;
  end

  // marks are whole carrier periods only
  function automatic int unsigned mark_len(int unsigned d);
    return (d / (2 * irtx_pkg::CARRIER_HALF_US)) * (2 * irtx_pkg::CARRIER_HALF_US);
  endfunction

  function automatic void enter_phase(irtx_pkg::phase_e p);
    irtx_pkg::phase_e p_eff;
    int unsigned      len;
    p_eff = p;
    len   = 0;
    case (p)
      irtx_pkg::PH_LEAD_MARK,
      irtx_pkg::PH_REP_MARK:   len = mark_len(irtx_pkg::LEADER_US);
      irtx_pkg::PH_LEAD_SPACE: len = irtx_pkg::LEADER_SPACE_US;
      irtx_pkg::PH_BIT_MARK,
      irtx_pkg::PH_STOP_MARK,
      irtx_pkg::PH_REP_STOP:   len = mark_len(irtx_pkg::BIT_MARK_US);
      // pulse-distance coding: a one gets the long space
      irtx_pkg::PH_BIT_SPACE:
        len = shift_q[31] ? 3 * (irtx_pkg::BIT_MARK_US + 90) : irtx_pkg::BIT_MARK_US + 81;
      irtx_pkg::PH_GAP:        len = irtx_pkg::GAP_US;
      irtx_pkg::PH_REP_SPACE:  len = irtx_pkg::REPEAT_SPACE_US;
      irtx_pkg::PH_TAIL,
      irtx_pkg::PH_EXTRA:      len = irtx_pkg::TAIL_US;
      default:                 p_eff = irtx_pkg::PH_IDLE;
    endcase
    ph_q   = p_eff;
    left_q = len;
    carr_q = 0;
  endfunction

  function automatic irtx_pkg::phase_e next_phase(irtx_pkg::phase_e p);
    case (p)
      irtx_pkg::PH_LEAD_MARK:  return irtx_pkg::PH_LEAD_SPACE;
      irtx_pkg::PH_LEAD_SPACE: return irtx_pkg::PH_BIT_MARK;
      irtx_pkg::PH_BIT_MARK:   return irtx_pkg::PH_BIT_SPACE;
      irtx_pkg::PH_BIT_SPACE: begin
        shift_q = shift_q << 1;
        if (bits_q > 0) bits_q--;
        return (bits_q > 0) ? irtx_pkg::PH_BIT_MARK : irtx_pkg::PH_STOP_MARK;
      end
      irtx_pkg::PH_STOP_MARK:  return irtx_pkg::PH_GAP;
      irtx_pkg::PH_GAP:        return irtx_pkg::PH_REP_MARK;
      irtx_pkg::PH_REP_MARK:   return irtx_pkg::PH_REP_SPACE;
      irtx_pkg::PH_REP_SPACE:  return irtx_pkg::PH_REP_STOP;
      irtx_pkg::PH_REP_STOP:   return irtx_pkg::PH_TAIL;
      irtx_pkg::PH_TAIL:       return extra_q ? irtx_pkg::PH_EXTRA : irtx_pkg::PH_IDLE;
      irtx_pkg::PH_EXTRA: begin
        extra_q = 1'b0;
        return irtx_pkg::PH_IDLE;
      end
      default:                 return irtx_pkg::PH_IDLE;
    endcase
  endfunction

  // move on, skipping phases of zero length
  function automatic void step_phase();
    do
      enter_phase(next_phase(ph_q));
    while (ph_q != irtx_pkg::PH_IDLE && left_q == 0);
  endfunction

  // one microsecond tick: button byte in, IR output beat out
  function automatic irtx_pkg::res_t ir_tick(logic [7:0] btn);
    irtx_pkg::res_t r;
    bit             go;
    r = '0;
    if (ph_q == irtx_pkg::PH_IDLE) begin
      go = 1'b1;
      case (btn)
        irtx_pkg::BTN_POWER: begin
          if (pwr_on_q) begin
            shift_q  = reg_file.power_down_code;
            pwr_on_q = 1'b0;
          end else begin
            shift_q  = reg_file.power_up_code;
            pwr_on_q = 1'b1;
          end
        end
        irtx_pkg::BTN_VOL_UP:   shift_q = reg_file.volume_up_code;
        irtx_pkg::BTN_INPUT: begin
          shift_q = reg_file.input_select_code;
          extra_q = 1'b1;
        end
        irtx_pkg::BTN_VOL_DOWN: shift_q = reg_file.volume_down_code;
        irtx_pkg::BTN_MUTE:     shift_q = reg_file.mute_code;
        default:                go = 1'b0;
      endcase
      if (go) begin
        idle_cnt_q = '0;
        bits_q     = irtx_pkg::FRAME_BITS;
        enter_phase(irtx_pkg::PH_LEAD_MARK);
        if (left_q == 0) step_phase();
      end else begin
        idle_cnt_q = idle_cnt_q + 1'b1;
        if (idle_cnt_q >= reg_file.idle_limit) begin
          r.sleep_request = 1'b1;
          idle_cnt_q      = '0;
        end
      end
    end
    // the start tick already carries the first carrier sample
    if (ph_q != irtx_pkg::PH_IDLE) begin
      r.busy_res = 1'b1;
      r.ir_level = (ph_q inside {irtx_pkg::PH_LEAD_MARK, irtx_pkg::PH_BIT_MARK,
                                 irtx_pkg::PH_STOP_MARK, irtx_pkg::PH_REP_MARK,
                                 irtx_pkg::PH_REP_STOP}) &&
                   (carr_q < irtx_pkg::CARRIER_HALF_US);
      carr_q++;
      if (carr_q >= 2 * irtx_pkg::CARRIER_HALF_US) carr_q = 0;
      if (left_q > 0) left_q--;
      if (left_q == 0) step_phase();
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: beats come from button_q, change on the falling edge
  // --------------------------------------------------------------------------
  btn_beat_t      button_q[$];
  btn_beat_t      head_beat;
  irtx_pkg::res_t ir_out_q[$];   // predicted output beats, oldest first
  irtx_pkg::res_t head_res;
  bit             in_taken;      // slave beat accepted at the last rising edge
  bit             calm_now = 1'b0;
  int unsigned    pushed_cnt = 0;
  int unsigned    taken_cnt  = 0;
  int unsigned    err_cnt    = 0;
  int unsigned    cycle_cnt  = 0;
  int unsigned    hold_req   = 0;  // bumped to ask for a long sink stall
  int unsigned    hold_seen  = 0;
  int unsigned    hold_left  = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (button_q.size() != 0 &&
          (button_q[0].calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        head_beat = button_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= head_beat.buttons;
        calm_now      <= head_beat.calm;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sink: random stalls, plus one long hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm_now || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      err_cnt++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Rising edge: predict on accepted input beats, check output beats
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    in_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_taken) begin
      ir_out_q.push_back(ir_tick(s_axis_tdata));
      taken_cnt++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (ir_out_q.size() == 0) begin
        $error("m_axis_tdata: expected no beat, actual %0h", m_axis_tdata);
        err_cnt++;
      end else begin
        head_res = ir_out_q.pop_front();
        check_field("ir_level", 8'(head_res.ir_level), 8'(m_axis_tdata[0]));
        check_field("busy_res", 8'(head_res.busy_res), 8'(m_axis_tdata[1]));
        check_field("sleep_request", 8'(head_res.sleep_request), 8'(m_axis_tdata[2]));
        check_field("tdata pad", 8'h00, 8'(m_axis_tdata[7:3]));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("ir_remote_frame_transmitter_top test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_beat(input logic [7:0] b, input bit calm);
    while (button_q.size() >= QUEUE_DEPTH) @(posedge clk_i);
    button_q.push_back('{b, calm});
    pushed_cnt++;
  endtask

  // sender paused until every predicted beat came back
  task automatic wait_drained();
    while (button_q.size() != 0 || taken_cnt != pushed_cnt || ir_out_q.size() != 0)
      @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input irtx_pkg::cfg_idx_e idx, input logic [31:0] val);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      irtx_pkg::CFG_POWER_DOWN:   reg_file.power_down_code   = val;
      irtx_pkg::CFG_POWER_UP:     reg_file.power_up_code     = val;
      irtx_pkg::CFG_VOL_UP:       reg_file.volume_up_code    = val;
      irtx_pkg::CFG_VOL_DOWN:     reg_file.volume_down_code  = val;
      irtx_pkg::CFG_INPUT_SELECT: reg_file.input_select_code = val;
      irtx_pkg::CFG_MUTE:         reg_file.mute_code         = val;
      irtx_pkg::CFG_IDLE_LIMIT:   reg_file.idle_limit        = val[irtx_pkg::IdleW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // any byte that does not start a frame; often released or one pin low, else random
  function automatic logic [7:0] idle_byte();
    logic [7:0] v;
    case ($urandom_range(0, 3))
      0:       v = 8'hFF;
      1:       v = ~(8'h01 << $urandom_range(0, 7));
      default: v = 8'($urandom_range(0, 255));
    endcase
    while (v inside {irtx_pkg::BTN_POWER, irtx_pkg::BTN_VOL_UP, irtx_pkg::BTN_INPUT,
                     irtx_pkg::BTN_VOL_DOWN, irtx_pkg::BTN_MUTE})
      v = 8'($urandom_range(0, 255));
    return v;
  endfunction

  // while busy, half the beats are real buttons that must be ignored
  function automatic logic [7:0] busy_byte();
    case ($urandom_range(0, 9))
      0:       return irtx_pkg::BTN_POWER;
      1:       return irtx_pkg::BTN_VOL_UP;
      2:       return irtx_pkg::BTN_INPUT;
      3:       return irtx_pkg::BTN_VOL_DOWN;
      4:       return irtx_pkg::BTN_MUTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic idle_run(input int n);
    repeat (n) push_beat(idle_byte(), 1'b0);
  endtask

  // Press a button, then feed the first part of the leader mark as one
  // stretch without idle cycles on either side.
  task automatic start_frame(input logic [7:0] start_btn, input int n);
    push_beat(start_btn, 1'b0);
    repeat (n) push_beat(busy_byte(), 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // codes at their extremes or random, zero idle limit pulses on every idle tick
    write_reg(irtx_pkg::CFG_POWER_DOWN, 32'h0000_0000);
    write_reg(irtx_pkg::CFG_POWER_UP, $urandom());
    write_reg(irtx_pkg::CFG_VOL_UP, 32'h0000_0000);
    write_reg(irtx_pkg::CFG_VOL_DOWN, 32'hFFFF_FFFF);
    write_reg(irtx_pkg::CFG_INPUT_SELECT, 32'hFFFF_FFFF);
    write_reg(irtx_pkg::CFG_MUTE, $urandom());
    write_reg(irtx_pkg::CFG_IDLE_LIMIT, 32'd0);

    // directed idle bytes: all pins low, all released, single and paired pins
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'h80, 1'b0);
    push_beat(8'h7F, 1'b0);
    push_beat(8'h01, 1'b0);
    push_beat(8'hFD, 1'b0);
    push_beat(8'h7E, 1'b0);
    push_beat(8'hFC, 1'b0);

    write_reg(irtx_pkg::CFG_IDLE_LIMIT, 32'd1);
    push_beat(8'h55, 1'b0);
    push_beat(8'hAA, 1'b0);
    push_beat(8'hFF, 1'b0);

    write_reg(irtx_pkg::CFG_IDLE_LIMIT, 32'd3);
    repeat (7) push_beat(8'hFF, 1'b0);

    // random idle traffic under a random idle limit
    write_reg(irtx_pkg::CFG_IDLE_LIMIT, $urandom_range(2, 20));
    idle_run(175);

    // long sink hold-off while the source keeps offering beats
    write_reg(irtx_pkg::CFG_VOL_UP, $urandom());
    write_reg(irtx_pkg::CFG_IDLE_LIMIT, $urandom_range(5, 40));
    idle_run(40);
    hold_req++;
    idle_run(135);

    write_reg(irtx_pkg::CFG_MUTE, 32'hFFFF_FFFF);
    write_reg(irtx_pkg::CFG_IDLE_LIMIT, 32'hF_FFFF);
    idle_run(175);

    write_reg(irtx_pkg::CFG_VOL_DOWN, $urandom());
    write_reg(irtx_pkg::CFG_IDLE_LIMIT, $urandom_range(20, 60));
    idle_run(150);

    // first power press sends the up code; later buttons are ignored and
    // busy ticks must not count toward the idle limit
    write_reg(irtx_pkg::CFG_POWER_UP, $urandom());
    write_reg(irtx_pkg::CFG_IDLE_LIMIT, 32'd5);
    idle_run(6);
    start_frame(irtx_pkg::BTN_POWER, BUSY_BEATS);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0)
      $display("ir_remote_frame_transmitter_top test passed");
    else
      $display("ir_remote_frame_transmitter_top test failed");
    $finish;
  end

endmodule
